>>> hdl/pcrq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the per-cpu round-robin ready queue
// no dependencies

package pcrq_pkg;

   localparam int CMD_W    = 2;
   localparam int CPU_W    = 4;
   localparam int IDX_W    = 6;
   localparam int ONLINE_W = 4;

   // command codes, code 3 has no meaning
   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_PICK   = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // control from the sequencer to the bitmap memory
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctrl_type;

endpackage

>>> hdl/pcrq_req_if.sv
`timescale 1ns / 1ps
// command channel of the ready queue
// depends on pcrq_pkg

interface pcrq_req_if;
   logic                          valid;
   logic                          ready;
   logic [pcrq_pkg::CMD_W-1:0]    cmd;
   logic [pcrq_pkg::CPU_W-1:0]    cpu_id;
   logic [pcrq_pkg::IDX_W-1:0]    task_index;

   modport source (output valid, cmd, cpu_id, task_index, input ready);
   modport sink (input valid, cmd, cpu_id, task_index, output ready);
endinterface

>>> hdl/pcrq_rsp_if.sv
`timescale 1ns / 1ps
// result channel of the ready queue
// depends on pcrq_pkg

interface pcrq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pcrq_pkg::IDX_W-1:0]    picked_index;

   modport source (output valid, picked_index, input ready);
   modport sink (input valid, picked_index, output ready);
endinterface

>>> hdl/pcrq_csr_if.sv
`timescale 1ns / 1ps
// configuration write channel carrying the online cpu count
// depends on pcrq_pkg

interface pcrq_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pcrq_pkg::ONLINE_W-1:0]   online_cpus;

   modport source (output valid, online_cpus, input ready);
   modport sink (input valid, online_cpus, output ready);
endinterface

>>> hdl/per_cpu_round_robin_ready_queue.sv
`timescale 1ns / 1ps
// Per-CPU round-robin ready queue.
// One bitmap of MAX_TASKS bits per cpu lives in a memory with a
// registered read. A command item on req_ch adds (0) or removes (1) a task
// in the bitmap of a cpu, or picks (2) the next ready task after the start
// index, wrapping and skipping index 0; a pick returns one item on rsp_ch,
// 0 when nothing is ready. Add, remove and code 3 return nothing.
// A cpu_id at or above the online count (csr_ch, 0 taken as 1, clamped to
// MAX_CPUS) uses cpu 0. csr_ch is always ready; write it only while idle.
// Timing: an item is accepted in the idle state, the row is read at that
// edge and modified, written back or encoded in the following cycle. No
// new item is taken until the last has left execute, as the write-back
// must land before the next read. A pick result is registered as its
// execute cycle ends and is then shown on rsp_ch. If rsp_ch stalls with a
// result already held, a further pick waits in execute until the held
// result is taken. Reset clears all bitmaps (per-row valid bits, no
// clearing pass), sets online_cpus to 1 and empties the result register.
// Depends on pcrq_pkg, the channel interfaces, pcrq_ready_mem and pcrq_pick.

module per_cpu_round_robin_ready_queue #(
   parameter int MAX_TASKS = 64,
   parameter int MAX_CPUS  = 8
) (
   input logic        clock,
   input logic        reset,
   pcrq_req_if.sink   req_ch,
   pcrq_rsp_if.source rsp_ch,
   pcrq_csr_if.sink   csr_ch
);
   import pcrq_pkg::*;

   localparam int TW     = $clog2(MAX_TASKS);
   localparam int CW     = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
   localparam int CAP_W  = 7;
   localparam int TEXT_W = 11;

   state_type             state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [CW-1:0]         addr_ff, addr_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [ONLINE_W-1:0]   online_cpus_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      rsp_index_ff, rsp_index_in;

   logic                  req_fire;
   logic [CAP_W-1:0]      cap;
   logic [CAP_W-1:0]      cpu_ext;
   logic [CAP_W-1:0]      cpu_eff;
   mem_ctrl_type          mem_ctrl;
   logic [MAX_TASKS-1:0]  rd_word;
   logic [MAX_TASKS-1:0]  wr_word;
   logic [TEXT_W-1:0]     idx_ext;
   logic                  idx_legal;
   logic [IDX_W-1:0]      pick_result;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.picked_index = rsp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         online_cpus_ff <= ONLINE_W'(1);
      end else if (csr_ch.valid) begin
         online_cpus_ff <= csr_ch.online_cpus;
      end
   end

   // effective cpu row
   always_comb begin
      if (online_cpus_ff == '0) begin
         cap = CAP_W'(1);
      end else if (CAP_W'(online_cpus_ff) > CAP_W'(MAX_CPUS)) begin
         cap = CAP_W'(MAX_CPUS);
      end else begin
         cap = CAP_W'(online_cpus_ff);
      end
      cpu_ext = CAP_W'(req_ch.cpu_id);
      cpu_eff = (cpu_ext < cap) ? cpu_ext : '0;
   end

   pcrq_ready_mem #(
      .DEPTH (MAX_CPUS),
      .WIDTH (MAX_TASKS),
      .AW    (CW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mem_ctrl),
      .rd_addr (addr_in),
      .wr_addr (addr_ff),
      .wr_data (wr_word),
      .rd_data (rd_word)
   );

   pcrq_pick #(
      .MAX_TASKS (MAX_TASKS),
      .TW        (TW)
   ) u_pick (
      .ready_word   (rd_word),
      .start_index  (idx_ff),
      .picked_index (pick_result)
   );

   // read-modify-write of one bitmap bit
   always_comb begin
      idx_ext   = TEXT_W'(idx_ff);
      idx_legal = (idx_ff != '0) && (idx_ext < TEXT_W'(MAX_TASKS));
      wr_word   = rd_word;
      if (idx_legal) begin
         wr_word[idx_ext[TW-1:0]] = (cmd_ff == CMD_ADD);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_index_in = rsp_index_ff;
      mem_ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in         = req_ch.cmd;
               addr_in        = cpu_eff[CW-1:0];
               idx_in         = req_ch.task_index;
               mem_ctrl.rd_en = 1'b1;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               CMD_ADD, CMD_REMOVE: begin
                  mem_ctrl.wr_en = idx_legal;
                  state_in       = ST_IDLE;
               end
               CMD_PICK: begin
                  if (!rsp_valid_ff || rsp_ch.ready) begin
                     rsp_valid_in = 1'b1;
                     rsp_index_in = pick_result;
                     state_in     = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      idx_ff       <= idx_in;
      rsp_index_ff <= rsp_index_in;
   end

   // an accepted item always gets its execute cycle
   a_fire_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_EXEC)
      else $error("accepted item did not reach execute");

   // writes only happen in execute, never overlapping a read
   a_wr_exec: assert property (@(posedge clock) disable iff (reset)
      mem_ctrl.wr_en |-> (state_ff == ST_EXEC) && !mem_ctrl.rd_en)
      else $error("memory write outside execute");

   // a pick with a free result register delivers its result next cycle
   a_pick_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && cmd_ff == CMD_PICK && (!rsp_valid_ff || rsp_ch.ready))
      |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("pick result not loaded");

endmodule

>>> hdl/pcrq_ready_mem.sv
`timescale 1ns / 1ps
// bitmap memory, one row per cpu, registered read, per-row valid bits
// depends on pcrq_pkg

module pcrq_ready_mem #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 64,
   parameter int AW    = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pcrq_pkg::mem_ctrl_type ctrl,
   input  logic [AW-1:0]          rd_addr,
   input  logic [AW-1:0]          wr_addr,
   input  logic [WIDTH-1:0]       wr_data,
   output logic [WIDTH-1:0]       rd_data
);
   import pcrq_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] row_valid_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // a row never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (ctrl.wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (ctrl.rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> hdl/pcrq_pick.sv
`timescale 1ns / 1ps
// rotating priority encoder: first set bit after the start index, skipping 0
// depends on pcrq_pkg

module pcrq_pick #(
   parameter int MAX_TASKS = 64,
   parameter int TW        = 6
) (
   input  logic [MAX_TASKS-1:0]       ready_word,
   input  logic [pcrq_pkg::IDX_W-1:0] start_index,
   output logic [pcrq_pkg::IDX_W-1:0] picked_index
);
   import pcrq_pkg::*;

   localparam int START_VALUES = 2 ** IDX_W;

   logic [TW-1:0]        start_mod;
   logic [MAX_TASKS-1:0] cand;
   logic [MAX_TASKS-1:0] upper;
   logic [TW-1:0]        upper_idx;
   logic                 upper_any;
   logic [TW-1:0]        lower_idx;
   logic                 lower_any;
   logic [TW-1:0]        found;

   // start index modulo task count as a small constant table
   always_comb begin
      start_mod = '0;
      for (int v = 0; v < START_VALUES; v++) begin
         if (start_index == IDX_W'(v)) begin
            start_mod = TW'(v % MAX_TASKS);
         end
      end
   end

   always_comb begin
      cand    = ready_word;
      cand[0] = 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         upper[i] = cand[i] && (TW'(i) > start_mod);
      end
   end

   // lowest set bit above the start, else lowest set bit overall
   always_comb begin
      upper_idx = '0;
      upper_any = 1'b0;
      lower_idx = '0;
      lower_any = 1'b0;
      for (int i = MAX_TASKS - 1; i > 0; i--) begin
         if (upper[i]) begin
            upper_idx = TW'(i);
            upper_any = 1'b1;
         end
         if (cand[i]) begin
            lower_idx = TW'(i);
            lower_any = 1'b1;
         end
      end
      if (upper_any) begin
         found = upper_idx;
      end else if (lower_any) begin
         found = lower_idx;
      end else begin
         found = '0;
      end
   end

   assign picked_index = IDX_W'(found);

endmodule
